// ===== src/bng_pkg.sv =====
package bng_pkg;

   localparam int SAMPLE_W = 8;
   localparam int SUM_W    = 14;
   // wide enough for (min + delta) * len and sum + delta * len at the 64-sample cap
   localparam int CMP_W    = 16;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_DELTA   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE = 1'b1;

   localparam logic [SAMPLE_W-1:0] DELTA_RESET   = 8'd10;
   localparam logic [SAMPLE_W-1:0] SILENCE_RESET = 8'd128;
   localparam logic [SAMPLE_W-1:0] MIN_RESET     = 8'd255;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                stream_end;
   } req_item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] out_sample;
      logic                was_silenced;
      logic                burst_last;
   } rsp_item_type;

   typedef struct packed {
      logic accept;   // store sample and update running stats
      logic judge;    // latch verdict and count, clear stats, start read at entry 0
      logic advance;  // result taken, move to next entry
   } bng_cmd_type;

   typedef struct packed {
      logic block_done;  // sample at the input closes the block
      logic burst_last;  // current result is the last of the burst
   } bng_sts_type;

endpackage

// ===== src/block_noise_gate.sv =====
// A closing item's first result follows the judge state and the registered store read.
// Throughput: one item accepted per cycle while a block fills; once a block closes,
// input waits through the judge state and the whole burst, whose results leave one
// at a time through the single store read port.
// Reset (synchronous): running stats cleared, delta = 10, silence level = 128;
// store contents are not cleared.
module block_noise_gate #(
   parameter int BLOCK_LEN = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bng_pkg::req_item_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bng_pkg::rsp_item_type          rsp_data,
   input  logic                           csr_we,
   input  logic [bng_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [bng_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bng_pkg::*;

   bng_cmd_type cmd;
   bng_sts_type sts;

   bng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bng_datapath #(
      .BLOCK_LEN (BLOCK_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== src/bng_ctrl.sv =====
module bng_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bng_pkg::bng_sts_type sts,
   output bng_pkg::bng_cmd_type cmd
);
   import bng_pkg::*;

   localparam logic [1:0] S_COLLECT = 2'd0;
   localparam logic [1:0] S_JUDGE   = 2'd1;
   localparam logic [1:0] S_EMIT    = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         S_COLLECT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.block_done) begin
                  state_in = S_JUDGE;
               end
            end
         end
         S_JUDGE: begin
            cmd.judge = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (sts.burst_last) begin
                  state_in = S_COLLECT;
               end
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/bng_datapath.sv =====
module bng_datapath #(
   parameter int BLOCK_LEN = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bng_pkg::req_item_type               req_data,
   output bng_pkg::rsp_item_type               rsp_data,
   input  logic                                csr_we,
   input  logic [bng_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [bng_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  bng_pkg::bng_cmd_type                cmd,
   output bng_pkg::bng_sts_type                sts
);
   import bng_pkg::*;

   localparam int IDX_W  = $clog2(BLOCK_LEN);
   localparam int FILL_W = $clog2(BLOCK_LEN + 1);

   logic [SAMPLE_W-1:0] store_mem [BLOCK_LEN];

   logic [SAMPLE_W-1:0] delta_ff;
   logic [SAMPLE_W-1:0] silence_lvl_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;
   logic [SAMPLE_W-1:0] run_min_ff;
   logic [SAMPLE_W-1:0] run_max_ff;
   logic [SUM_W-1:0]    run_sum_ff;
   logic [FILL_W-1:0]   count_ff;
   logic                silence_ff;
   logic [FILL_W-1:0]   idx_ff;
   logic [FILL_W-1:0]   idx_in;
   logic [SAMPLE_W-1:0] rd_data_ff;

   logic [CMP_W-1:0] len_c;
   logic [CMP_W-1:0] low_lhs;
   logic [CMP_W-1:0] high_lhs;
   logic [CMP_W-1:0] high_rhs;
   logic             quiet;
   logic             full;

   assign fill_in = fill_ff + FILL_W'(1);
   assign sts.block_done = (fill_in == FILL_W'(BLOCK_LEN)) || req_data.stream_end;
   assign sts.burst_last = ((idx_ff + FILL_W'(1)) == count_ff);

   // verdict on the completed block
   assign len_c    = CMP_W'(BLOCK_LEN);
   assign low_lhs  = (CMP_W'(run_min_ff) + CMP_W'(delta_ff)) * len_c;
   assign high_lhs = CMP_W'(run_sum_ff) + CMP_W'(delta_ff) * len_c;
   assign high_rhs = CMP_W'(run_max_ff) * len_c;
   assign quiet    = (low_lhs > CMP_W'(run_sum_ff)) && (high_lhs > high_rhs);
   assign full     = (fill_ff == FILL_W'(BLOCK_LEN));

   // read address runs one ahead on a take so data is ready next cycle
   always_comb begin
      idx_in = idx_ff;
      if (cmd.judge) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         store_mem[fill_ff[IDX_W-1:0]] <= req_data.sample;
      end
      rd_data_ff <= store_mem[idx_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff       <= DELTA_RESET;
         silence_lvl_ff <= SILENCE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DELTA:   delta_ff       <= csr_wdata;
            CSR_SILENCE: silence_lvl_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         run_min_ff <= MIN_RESET;
         run_max_ff <= '0;
         run_sum_ff <= '0;
         idx_ff     <= '0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.judge) begin
            fill_ff    <= '0;
            run_min_ff <= MIN_RESET;
            run_max_ff <= '0;
            run_sum_ff <= '0;
         end else if (cmd.accept) begin
            fill_ff <= fill_in;
            if (req_data.sample < run_min_ff) begin
               run_min_ff <= req_data.sample;
            end
            if (req_data.sample > run_max_ff) begin
               run_max_ff <= req_data.sample;
            end
            run_sum_ff <= run_sum_ff + SUM_W'(req_data.sample);
         end
      end
   end

   // a partial block is always silenced
   always_ff @(posedge clock) begin
      if (cmd.judge) begin
         count_ff   <= fill_ff;
         silence_ff <= !full || quiet;
      end
   end

   always_comb begin
      rsp_data.out_sample   = silence_ff ? silence_lvl_ff : rd_data_ff;
      rsp_data.was_silenced = silence_ff;
      rsp_data.burst_last   = sts.burst_last;
   end

endmodule

// ===== test/tb_block_noise_gate.sv =====
module tb_block_noise_gate;
   timeunit 1ns;
   timeprecision 1ps;

   import bng_pkg::*;

   localparam int BLOCK_LEN   = 64;
   localparam int ITEM_TARGET = 360;
   localparam int HOLD_CYCLES = 400;

   typedef enum int {SHAPE_CONST, SHAPE_BAND, SHAPE_WIDE, SHAPE_EDGE} shape_kind;

   // Tracks block fill and running stats, and queues the gated bursts due.
   class gate_scoreboard;
      logic [SAMPLE_W-1:0] store_mem [BLOCK_LEN];
      int                  fill;
      logic [SAMPLE_W-1:0] run_min;
      logic [SAMPLE_W-1:0] run_max;
      logic [SUM_W-1:0]    run_sum;
      logic [SAMPLE_W-1:0] delta_q;
      logic [SAMPLE_W-1:0] silence_q;
      rsp_item_type        gated_due[$];
      int                  errors;

      function new();
         delta_q   = DELTA_RESET;
         silence_q = SILENCE_RESET;
         errors    = 0;
         clear_block();
      endfunction

      function void clear_block();
         fill    = 0;
         run_min = MIN_RESET;
         run_max = '0;
         run_sum = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_DELTA:   delta_q = value;
            CSR_SILENCE: silence_q = value;
            default: ;
         endcase
      endfunction

      // both extremes strictly inside delta of the mean, scaled by the block length
      function bit block_quiet();
         int lo_lhs;
         int hi_lhs;
         lo_lhs = (int'(run_min) + int'(delta_q)) * BLOCK_LEN;
         hi_lhs = int'(run_sum) + int'(delta_q) * BLOCK_LEN;
         return (lo_lhs > int'(run_sum)) && (hi_lhs > int'(run_max) * BLOCK_LEN);
      endfunction

      function void queue_burst(int count, bit silence);
         rsp_item_type it;
         for (int k = 0; k < count; k++) begin
            it.out_sample   = silence ? silence_q : store_mem[k];
            it.was_silenced = silence;
            it.burst_last   = (k == count - 1);
            gated_due.push_back(it);
         end
      endfunction

      task note_sample(req_item_type it);
         store_mem[fill] = it.sample;
         fill++;
         if (it.sample < run_min) run_min = it.sample;
         if (it.sample > run_max) run_max = it.sample;
         run_sum = run_sum + it.sample;
         if (fill >= BLOCK_LEN) begin
            queue_burst(BLOCK_LEN, block_quiet());
            clear_block();
         end else if (it.stream_end) begin
            // partial block closed by end of stream: always silenced
            queue_burst(fill, 1'b1);
            clear_block();
         end
      endtask

      task report(string msg);
         errors++;
         $display("%0t ERROR %s", $time, msg);
      endtask

      task check_result(rsp_item_type got);
         rsp_item_type want;
         if (gated_due.size() == 0) begin
            report($sformatf("unexpected item out=%0d sil=%0b last=%0b",
                             got.out_sample, got.was_silenced, got.burst_last));
            return;
         end
         want = gated_due.pop_front();
         if (got.out_sample !== want.out_sample)
            report($sformatf("out_sample %0d, expected %0d", got.out_sample, want.out_sample));
         if (got.was_silenced !== want.was_silenced)
            report($sformatf("was_silenced %0b, expected %0b",
                             got.was_silenced, want.was_silenced));
         if (got.burst_last !== want.burst_last)
            report($sformatf("burst_last %0b, expected %0b", got.burst_last, want.burst_last));
      endtask

      task close_out();
         if (gated_due.size() != 0)
            report($sformatf("%0d items never came out", gated_due.size()));
      endtask
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   req_item_type          req_data  = '0;
   logic                  rsp_ready = 1'b0;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_ready;
   logic                  rsp_valid;
   rsp_item_type          rsp_data;

   gate_scoreboard sb;
   int  items_sent = 0;
   bit  req_steady = 1'b0;
   bit  rsp_steady = 1'b0;
   bit  hold_rsp   = 1'b0;

   block_noise_gate #(
      .BLOCK_LEN(BLOCK_LEN)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // result side: random stalls, plus one long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!rsp_steady) stall_left = pick_gap();
         end
      end
   end

   // the item is noted here, at its accepting edge, so block state is current for the caller
   task automatic send_item(input logic [SAMPLE_W-1:0] value, input logic last_flag);
      req_item_type it;
      int gap;
      it.sample     = value;
      it.stream_end = last_flag;
      req_data  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(it);
      items_sent++;
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] delta,
                             input logic [CSR_DATA_W-1:0] silence);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_DELTA;
      csr_wdata <= delta;
      @(posedge clock);
      sb.write_reg(CSR_DELTA, delta);
      csr_addr  <= CSR_SILENCE;
      csr_wdata <= silence;
      @(posedge clock);
      sb.write_reg(CSR_SILENCE, silence);
      csr_we <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] shaped_sample(shape_kind kind, int center, int width,
                                                         int fixed);
      int v;
      case (kind)
         SHAPE_CONST: v = fixed;
         SHAPE_BAND:  v = center + $urandom_range(0, 2 * width) - width;
         SHAPE_EDGE:  v = $urandom_range(0, 1) ? 255 : 0;
         default:     v = $urandom_range(0, 255);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic send_block(input int len, input shape_kind kind, input bit end_last);
      int center;
      int width;
      int fixed;
      center = $urandom_range(0, 255);
      width  = $urandom_range(0, 12);
      fixed  = $urandom_range(0, 255);
      for (int k = 0; k < len; k++)
         send_item(shaped_sample(kind, center, width, fixed), end_last && (k == len - 1));
   endtask

   // noise: loose items with an occasional stream end anywhere
   task automatic send_noise(input int len);
      for (int k = 0; k < len; k++)
         send_item(SAMPLE_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (sb.gated_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      int r;
      int ph;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one-item streams at the extremes, silence equal to the sample,
      // short partial blocks toggling every sample bit
      send_item(8'd0, 1'b1);
      send_item(8'd255, 1'b1);
      send_item(8'h55, 1'b0);
      send_item(8'hAA, 1'b0);
      send_item(8'h0F, 1'b1);
      wait_until_drained();
      set_config(8'd10, 8'd200);
      send_item(8'd200, 1'b1);
      send_item(8'hF0, 1'b0);
      send_item(8'h01, 1'b1);
      wait_until_drained();

      ph = 0;
      while (items_sent < ITEM_TARGET) begin
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         case (ph)
            0: begin
               // constant block with zero band: equality, so not quiet
               set_config(8'd0, 8'd0);
               send_block(BLOCK_LEN, SHAPE_CONST, 1'b0);
            end
            1: begin
               // constant block, band of one, stream end on the closing sample
               set_config(8'd1, 8'd255);
               send_block(BLOCK_LEN, SHAPE_CONST, 1'b1);
            end
            2: begin
               set_config(8'd255, CSR_DATA_W'($urandom_range(0, 255)));
               req_steady = 1'b1;
               hold_rsp   = 1'b1;
               send_block(BLOCK_LEN, SHAPE_WIDE, 1'b0);
               send_block($urandom_range(1, BLOCK_LEN - 1), SHAPE_BAND, 1'b1);
            end
            default: begin
               r = $urandom_range(0, 9);
               set_config((r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
                          CSR_DATA_W'($urandom_range(0, 40)),
                          CSR_DATA_W'($urandom_range(0, 255)));
               repeat (2) begin
                  r = $urandom_range(0, 99);
                  if (r < 50)
                     send_block(BLOCK_LEN, shape_kind'($urandom_range(0, 3)),
                                $urandom_range(0, 3) == 0);
                  else if (r < 80)
                     send_block($urandom_range(1, BLOCK_LEN - 1),
                                shape_kind'($urandom_range(0, 3)), 1'b1);
                  else
                     send_noise($urandom_range(1, 20));
               end
            end
         endcase
         // close any open block so the next register write finds the block empty
         if (sb.fill != 0) send_item(SAMPLE_W'($urandom_range(0, 255)), 1'b1);
         wait_until_drained();
         ph++;
      end

      sb.close_out();
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
